[rtl/bud_pkg.sv]
package bud_pkg;

	localparam int ADDR_W  = 9;
	localparam int LVL_W   = 4;
	localparam int NODE_W  = ADDR_W + 1;
	localparam int BIT_W   = 4;
	localparam int ROW_BITS = 1 << BIT_W;
	localparam int ROW_W   = NODE_W - BIT_W;
	localparam int ROWS    = 1 << ROW_W;
	localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(ADDR_W);

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_SPACE = 2'd1;
	localparam logic [1:0] ST_NOT_ALLOC = 2'd2;

	typedef struct packed {
		logic              req_type;
		logic [LVL_W-1:0]  size_log;
		logic [ADDR_W-1:0] free_addr;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ADDR_W-1:0] block_addr;
	} rsp_t;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_DECODE, S_SRCH_RD, S_SRCH_CHK, S_SPLIT_RD, S_SPLIT_WR,
		S_AL_RD, S_AL_WR, S_FR_RD, S_FR_CHK, S_MG_RD, S_MG_CHK, S_SF_RD,
		S_SF_WR, S_REPLY
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_CLR, OP_LOAD, OP_ALLOC_INIT, OP_FREE_INIT, OP_ERR_SPACE,
		OP_ERR_FREE, OP_SRCH_RD, OP_SRCH_CHK, OP_SPLIT_RD, OP_SPLIT_WR,
		OP_AL_RD, OP_AL_WR, OP_FR_RD, OP_FR_CHK, OP_MG_RD, OP_MG_CHK,
		OP_SF_RD, OP_SF_WR
	} dp_op_t;

	typedef struct packed {
		logic is_free;
		logic lvl_bad;
		logic misaligned;
		logic hit;
		logic row_last;
		logic k_top;
		logic split_last;
		logic split_next;
		logic alloc_bit;
		logic bud_bit;
		logic merge_last;
		logic clr_last;
	} dp_flags_t;

endpackage

[rtl/buddy_allocator_top.sv]
// Channel   Signals                 Transfer
// request   start, busy, req        at a clock edge with start high and busy low
// result    done, rsp               at the clock edge that ends the cycle done is high
//
// After reset the block clears its mark stores row by row, with busy high.
// An allocation decodes the request, scans the 16-node rows at and above the
// requested level, splits the found block one level at a time and marks it.
// A free checks the block is allocated, then merges level by level; one request is in flight.
// Results cannot be stalled: done is high for one cycle per request.
module buddy_allocator_top import bud_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	dp_op_t    op;
	dp_flags_t flags;

	// The controller sequences each request; the datapath owns the two mark
	// stores (free and allocated, 16 nodes per row) and the walk registers.
	bud_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.flags  (flags),
		.op     (op),
		.busy   (busy),
		.done   (done)
	);

	bud_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.req    (req),
		.flags  (flags),
		.rsp    (rsp)
	);

endmodule

[rtl/bud_ctrl.sv]
module bud_ctrl import bud_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  dp_flags_t flags,
	output dp_op_t    op,
	output logic      busy,
	output logic      done
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		op      = OP_NONE;
		busy    = (state_q != S_IDLE);
		done    = 1'b0;
		case (state_q)
			S_CLR: begin
				op = OP_CLR;
				if (flags.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					op      = OP_LOAD;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (!flags.is_free) begin
					if (flags.lvl_bad) begin
						op      = OP_ERR_SPACE;
						state_d = S_REPLY;
					end else begin
						op      = OP_ALLOC_INIT;
						state_d = S_SRCH_RD;
					end
				end else if (flags.lvl_bad || flags.misaligned) begin
					op      = OP_ERR_FREE;
					state_d = S_REPLY;
				end else begin
					op      = OP_FREE_INIT;
					state_d = S_FR_RD;
				end
			end
			S_SRCH_RD: begin
				op      = OP_SRCH_RD;
				state_d = S_SRCH_CHK;
			end
			S_SRCH_CHK: begin
				op = OP_SRCH_CHK;
				if (flags.hit) begin
					state_d = flags.split_last ? S_AL_RD : S_SPLIT_RD;
				end else if (flags.row_last && flags.k_top) begin
					state_d = S_REPLY;
				end else begin
					state_d = S_SRCH_RD;
				end
			end
			S_SPLIT_RD: begin
				op      = OP_SPLIT_RD;
				state_d = S_SPLIT_WR;
			end
			S_SPLIT_WR: begin
				op      = OP_SPLIT_WR;
				state_d = flags.split_next ? S_AL_RD : S_SPLIT_RD;
			end
			S_AL_RD: begin
				op      = OP_AL_RD;
				state_d = S_AL_WR;
			end
			S_AL_WR: begin
				op      = OP_AL_WR;
				state_d = S_REPLY;
			end
			S_FR_RD: begin
				op      = OP_FR_RD;
				state_d = S_FR_CHK;
			end
			S_FR_CHK: begin
				op = OP_FR_CHK;
				if (!flags.alloc_bit) state_d = S_REPLY;
				else if (flags.k_top) state_d = S_SF_RD;
				else state_d = S_MG_RD;
			end
			S_MG_RD: begin
				op      = OP_MG_RD;
				state_d = S_MG_CHK;
			end
			S_MG_CHK: begin
				op = OP_MG_CHK;
				if (!flags.bud_bit) state_d = S_REPLY;
				else if (flags.merge_last) state_d = S_SF_RD;
				else state_d = S_MG_RD;
			end
			S_SF_RD: begin
				op      = OP_SF_RD;
				state_d = S_SF_WR;
			end
			S_SF_WR: begin
				op      = OP_SF_WR;
				state_d = S_REPLY;
			end
			S_REPLY: begin
				done    = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

[rtl/bud_dp.sv]
module bud_dp import bud_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  dp_op_t    op,
	input  req_t      req,
	output dp_flags_t flags,
	output rsp_t      rsp
);

	// Both mark stores hold 16 nodes per row; node 1 is the whole pool and
	// node (1 << (9 - k)) + p is block p at level k.
	logic [ROW_BITS-1:0] free_mem [ROWS];
	logic [ROW_BITS-1:0] alloc_mem [ROWS];
	logic [ROW_BITS-1:0] fm_rd_q, am_rd_q;

	logic [ROW_W-1:0]  clr_q;
	logic              type_q;
	logic [LVL_W-1:0]  lvl_q, k_q;
	logic [ADDR_W-1:0] addr_q;
	logic [NODE_W-1:0] n_q;
	logic [ROW_W-1:0]  r_q;
	rsp_t              res_q;

	logic              fm_re, fm_we, am_re, am_we;
	logic [ROW_W-1:0]  fm_ra, fm_wa, am_ra, am_wa;
	logic [ROW_BITS-1:0] fm_wd, am_wd;

	logic [ROW_BITS-1:0] lvl_mask, hit_vec;
	logic [BIT_W-1:0]  hit_bit;
	logic [NODE_W-1:0] up_node, free_node, shl_node;
	logic [BIT_W-1:0]  nb, bb, ub;

	function automatic logic [ROW_W-1:0] first_row(input logic [LVL_W-1:0] k);
		logic [NODE_W-1:0] v;
		v = NODE_W'(1) << (TOP_LVL - k);
		return v[NODE_W-1:BIT_W];
	endfunction

	function automatic logic [ROW_W-1:0] last_row(input logic [LVL_W-1:0] k);
		logic [NODE_W:0] v;
		v = ((NODE_W+1)'(1) << (TOP_LVL + LVL_W'(1) - k)) - (NODE_W+1)'(1);
		return v[NODE_W-1:BIT_W];
	endfunction

	always_comb begin
		for (int b = 0; b < ROW_BITS; b++) begin
			lvl_mask[b] = (({r_q, BIT_W'(b)} >> (TOP_LVL - k_q)) == NODE_W'(1));
		end
		hit_vec = fm_rd_q & lvl_mask;
		hit_bit = '0;
		for (int b = ROW_BITS - 1; b >= 0; b--) begin
			if (hit_vec[b]) hit_bit = BIT_W'(b);
		end
	end

	assign nb        = n_q[BIT_W-1:0];
	assign bb        = nb ^ BIT_W'(1);
	assign up_node   = {n_q[NODE_W-2:0], 1'b1};
	assign ub        = up_node[BIT_W-1:0];
	assign free_node = {1'b1, req.free_addr} >> req.size_log;
	assign shl_node  = n_q << lvl_q;

	assign flags.is_free    = type_q;
	assign flags.lvl_bad    = (lvl_q > TOP_LVL);
	assign flags.misaligned = ((addr_q & ~({ADDR_W{1'b1}} << lvl_q)) != '0);
	assign flags.hit        = (hit_vec != '0);
	assign flags.row_last   = (r_q == last_row(k_q));
	assign flags.k_top      = (k_q == TOP_LVL);
	assign flags.split_last = (k_q == lvl_q);
	assign flags.split_next = (k_q == lvl_q + LVL_W'(1));
	assign flags.alloc_bit  = am_rd_q[nb];
	assign flags.bud_bit    = fm_rd_q[bb];
	assign flags.merge_last = (k_q == TOP_LVL - LVL_W'(1));
	assign flags.clr_last   = (clr_q == ROW_W'(ROWS - 1));

	assign rsp = res_q;

	always_comb begin
		fm_re = 1'b0; fm_ra = n_q[NODE_W-1:BIT_W];
		fm_we = 1'b0; fm_wa = n_q[NODE_W-1:BIT_W]; fm_wd = fm_rd_q;
		am_re = 1'b0; am_ra = n_q[NODE_W-1:BIT_W];
		am_we = 1'b0; am_wa = n_q[NODE_W-1:BIT_W]; am_wd = am_rd_q;
		case (op)
			OP_CLR: begin
				fm_we = 1'b1; fm_wa = clr_q;
				fm_wd = (clr_q == '0) ? ROW_BITS'(2) : '0;
				am_we = 1'b1; am_wa = clr_q; am_wd = '0;
			end
			OP_SRCH_RD: begin
				fm_re = 1'b1; fm_ra = r_q;
			end
			OP_SRCH_CHK: begin
				fm_we = flags.hit; fm_wa = r_q;
				fm_wd = fm_rd_q & ~(ROW_BITS'(1) << hit_bit);
			end
			OP_SPLIT_RD: begin
				fm_re = 1'b1; fm_ra = up_node[NODE_W-1:BIT_W];
			end
			OP_SPLIT_WR: begin
				fm_we = 1'b1; fm_wa = up_node[NODE_W-1:BIT_W];
				fm_wd = fm_rd_q | (ROW_BITS'(1) << ub);
			end
			OP_AL_RD, OP_FR_RD: begin
				am_re = 1'b1;
			end
			OP_AL_WR: begin
				am_we = 1'b1; am_wd = am_rd_q | (ROW_BITS'(1) << nb);
			end
			OP_FR_CHK: begin
				am_we = flags.alloc_bit; am_wd = am_rd_q & ~(ROW_BITS'(1) << nb);
			end
			OP_MG_RD, OP_SF_RD: begin
				fm_re = 1'b1;
			end
			OP_MG_CHK: begin
				fm_we = 1'b1;
				fm_wd = flags.bud_bit ? (fm_rd_q & ~(ROW_BITS'(1) << bb))
				                      : (fm_rd_q | (ROW_BITS'(1) << nb));
			end
			OP_SF_WR: begin
				fm_we = 1'b1; fm_wd = fm_rd_q | (ROW_BITS'(1) << nb);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (fm_we) free_mem[fm_wa] <= fm_wd;
		if (fm_re) fm_rd_q <= free_mem[fm_ra];
		if (am_we) alloc_mem[am_wa] <= am_wd;
		if (am_re) am_rd_q <= alloc_mem[am_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (op == OP_CLR) begin
			clr_q <= clr_q + ROW_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				type_q <= req.req_type;
				lvl_q  <= req.size_log;
				addr_q <= req.free_addr;
				k_q    <= req.size_log;
				n_q    <= free_node;
			end
			OP_ALLOC_INIT: begin
				r_q <= first_row(lvl_q);
			end
			OP_ERR_SPACE: begin
				res_q <= '{status: ST_NO_SPACE, block_addr: '0};
			end
			OP_ERR_FREE: begin
				res_q <= '{status: ST_NOT_ALLOC, block_addr: '0};
			end
			OP_SRCH_CHK: begin
				if (flags.hit) begin
					n_q <= {r_q, hit_bit};
				end else if (flags.row_last) begin
					if (flags.k_top) begin
						res_q <= '{status: ST_NO_SPACE, block_addr: '0};
					end else begin
						k_q <= k_q + LVL_W'(1);
						r_q <= first_row(k_q + LVL_W'(1));
					end
				end else begin
					r_q <= r_q + ROW_W'(1);
				end
			end
			OP_SPLIT_WR: begin
				n_q <= {n_q[NODE_W-2:0], 1'b0};
				k_q <= k_q - LVL_W'(1);
			end
			OP_AL_WR: begin
				res_q <= '{status: ST_OK, block_addr: shl_node[ADDR_W-1:0]};
			end
			OP_FR_CHK: begin
				if (flags.alloc_bit) res_q <= '{status: ST_OK, block_addr: addr_q};
				else res_q <= '{status: ST_NOT_ALLOC, block_addr: '0};
			end
			OP_MG_CHK: begin
				if (flags.bud_bit) begin
					n_q <= n_q >> 1;
					k_q <= k_q + LVL_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[rtl/bud_checker.sv]
module bud_checker import bud_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rsp_t rsp
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy did not rise after a transfer");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held longer than one cycle");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result shown while idle");

	a_err_addr: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != ST_OK |-> rsp.block_addr == '0)
		else $error("error result carries an address");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.status == ST_OK || rsp.status == ST_NO_SPACE ||
		rsp.status == ST_NOT_ALLOC) else $error("undefined status code");

endmodule

bind buddy_allocator_top bud_checker u_bud_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

[dv/buddy_allocator_checker.sv]
`timescale 1ns / 1ps

module buddy_allocator_checker import bud_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  req_t req,
	input  logic done,
	input  rsp_t rsp,
	output int   fail_count,
	output int   pending,
	output int   alloc_ok,
	output int   free_ok,
	output int   err_count
);

	localparam int NODES = 1023;
	localparam int POOL = 512;

	bit   free_map [NODES];
	bit   used_map [NODES];
	rsp_t expected_rsp [$];
	int   mismatches;

	function automatic int node_index(int lv, int pos);
		return (POOL >> lv) - 1 + pos;
	endfunction

	// Applies one request to the shadow trees and returns the response it should produce.
	function automatic rsp_t apply_request(req_t r);
		rsp_t o;
		int lv, k, p, pos, a;
		bit found;
		o.status = ST_NO_SPACE;
		o.block_addr = '0;
		lv = r.size_log;
		found = 0;
		pos = 0;
		if (r.req_type == 1'b0) begin
			if (lv > 9)
				return o;
			for (k = lv; k <= 9 && !found; k++) begin
				for (p = 0; p < (POOL >> k); p++) begin
					if (free_map[node_index(k, p)]) begin
						free_map[node_index(k, p)] = 0;
						pos = p;
						found = 1;
						break;
					end
				end
				if (found)
					break;
			end
			if (!found)
				return o;
			while (k > lv) begin
				k--;
				pos = pos << 1;
				free_map[node_index(k, pos + 1)] = 1;
			end
			used_map[node_index(lv, pos)] = 1;
			o.status = ST_OK;
			o.block_addr = ADDR_W'(pos << lv);
		end else begin
			o.status = ST_NOT_ALLOC;
			a = r.free_addr;
			if (lv > 9)
				return o;
			if ((a & ((1 << lv) - 1)) != 0)
				return o;
			pos = a >> lv;
			if (!used_map[node_index(lv, pos)])
				return o;
			used_map[node_index(lv, pos)] = 0;
			while (lv < 9 && free_map[node_index(lv, pos ^ 1)]) begin
				free_map[node_index(lv, pos ^ 1)] = 0;
				pos >>= 1;
				lv++;
			end
			free_map[node_index(lv, pos)] = 1;
			o.status = ST_OK;
			o.block_addr = r.free_addr;
		end
		return o;
	endfunction

	assign pending = expected_rsp.size();

	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_r;
		if (!arst_n) begin
			foreach (free_map[i]) begin
				free_map[i] = 0;
				used_map[i] = 0;
			end
			free_map[0] = 1;
			expected_rsp.delete();
			fail_count <= 0;
			mismatches = 0;
			alloc_ok <= 0;
			free_ok <= 0;
			err_count <= 0;
		end else begin
			if (done) begin
				if (expected_rsp.size() == 0) begin
					fail_count <= fail_count + 1;
					if (mismatches < 10)
						$display("unexpected response status=%0d addr=%0d",
							rsp.status, rsp.block_addr);
					mismatches++;
				end else begin
					exp_r = expected_rsp.pop_front();
					if (rsp !== exp_r) begin
						fail_count <= fail_count + 1;
						if (mismatches < 10)
							$display("response mismatch: expected status=%0d addr=%0d, got status=%0d addr=%0d",
								exp_r.status, exp_r.block_addr, rsp.status, rsp.block_addr);
						mismatches++;
					end
				end
			end
			if (start && !busy) begin
				exp_r = apply_request(req);
				expected_rsp.push_back(exp_r);
				if (exp_r.status != ST_OK)
					err_count <= err_count + 1;
				else if (req.req_type)
					free_ok <= free_ok + 1;
				else
					alloc_ok <= alloc_ok + 1;
			end
		end
	end

endmodule

[dv/tb_buddy_allocator_top.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the buddy allocator. The checker beside the block keeps
// its own copy of the free and allocated trees, so this module only has to make
// interesting request streams: directed corner cases first, then random traffic
// that mostly frees blocks it really holds, so that merges reach deep levels.
module tb_buddy_allocator_top;
	import bud_pkg::*;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;
	int   fail_count, pending, alloc_ok, free_ok, err_count;

	// Blocks we believe we hold, tracked from the responses we see.
	logic [ADDR_W-1:0] held_addr [$];
	logic [LVL_W-1:0]  held_lvl [$];

	buddy_allocator_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .rsp(rsp)
	);

	buddy_allocator_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .fail_count(fail_count), .pending(pending),
		.alloc_ok(alloc_ok), .free_ok(free_ok), .err_count(err_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Waits a random gap, presents one request, holds it until
	// the transfer, then waits for its response. A gap of zero starts the next
	// request right at the edge that takes the previous response. Successful
	// allocations are remembered for freeing.
	task automatic issue(input logic kind, input logic [LVL_W-1:0] lv,
			input logic [ADDR_W-1:0] addr);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= '{req_type: kind, size_log: lv, free_addr: addr};
		@(posedge clk);
		while (busy)
			@(posedge clk);
		start <= 1'b0;
		do
			@(posedge clk);
		while (!done);
		if (!kind && rsp.status == ST_OK) begin
			held_addr.push_back(rsp.block_addr);
			held_lvl.push_back(lv);
		end
	endtask

	task automatic free_held(input int idx);
		logic [ADDR_W-1:0] a;
		logic [LVL_W-1:0] l;
		a = held_addr[idx];
		l = held_lvl[idx];
		held_addr.delete(idx);
		held_lvl.delete(idx);
		issue(1'b1, l, a);
	endtask

	task automatic release_all();
		while (held_addr.size() != 0)
			free_held($urandom_range(0, held_addr.size() - 1));
	endtask

	initial begin
		int n, i, pick, watchdog;
		start = 1'b0;
		req = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: whole pool, full pool, the bad-level and bad-address cases.
		issue(1'b0, TOP_LVL, '0);
		issue(1'b0, 4'd0, '0);            // pool full: no space
		issue(1'b1, 4'd0, 9'd0);          // unit 0 not allocated at level 0
		issue(1'b1, TOP_LVL, 9'd0);       // frees the whole pool
		issue(1'b0, 4'd10, '0);           // level too large on allocate
		issue(1'b0, 4'd15, '0);
		issue(1'b1, 4'd15, 9'd511);       // level too large on free
		issue(1'b0, 4'd0, 9'h1FF);        // unit at 0; address ignored
		issue(1'b0, 4'd0, '0);            // its buddy at 1
		issue(1'b1, 4'd1, 9'd1);          // misaligned free
		issue(1'b1, 4'd1, 9'd0);          // wrong level for unit 0
		issue(1'b0, 4'd3, '0);
		issue(1'b0, 4'd8, '0);
		issue(1'b0, 4'd8, '0);            // no space for a second half-pool
		issue(1'b1, 4'd0, 9'd2);          // free space, never allocated
		release_all();
		issue(1'b1, TOP_LVL, 9'd0);       // double free after full merge
		for (i = 0; i < 6; i++)
			issue(1'b0, 4'd0, '0);
		release_all();

		// Random: mostly valid allocate/free mixes, some noise. Small sizes dominate.
		for (n = 0; n < 500; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				issue(1'b0, ($urandom_range(0, 9) < 7) ? LVL_W'($urandom_range(0, 4))
					: LVL_W'($urandom_range(5, 9)), ADDR_W'($urandom));
			end else if (pick < 88 && held_addr.size() != 0) begin
				free_held($urandom_range(0, held_addr.size() - 1));
			end else begin
				issue(1'($urandom_range(0, 1)), LVL_W'($urandom_range(0, 15)),
					ADDR_W'($urandom));
			end
		end
		start <= 1'b0;
		release_all();
		start <= 1'b0;

		watchdog = 0;
		while (pending != 0 && watchdog < 2000) begin
			@(posedge clk);
			watchdog++;
		end
		repeat (200) @(posedge clk);
		$display("Covered %0d successful allocations, %0d successful frees, %0d error responses.",
			alloc_ok, free_ok, err_count);
		if (fail_count == 0 && pending == 0)
			$display("buddy_allocator_top regression: pass");
		else
			$display("buddy_allocator_top regression: fail");
		$finish;
	end

	initial begin
		#20ms;
		$display("buddy_allocator_top regression: fail");
		$finish;
	end

endmodule
